FILE: src/msrc_pkg.sv
package msrc_pkg;

  localparam int MOTOR_COUNT = 3;
  localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // step period = 2000 / pps, restoring divide one quotient bit a cycle
  localparam int             DIV_W      = 11;
  localparam logic [10:0]    DIVIDEND   = 11'd2000;
  localparam logic [3:0]     DIV_LAST   = 4'(DIV_W - 1);
  localparam logic [7:0]     PPS_MIN    = 8'd10;
  localparam logic [7:0]     PPS_MAX    = 8'd200;
  localparam logic [15:0]    ENDLESS    = 16'hffff;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_START   = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_POWER   = 3'd3,
    MODE_ALL_OFF = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  motor;
    logic [1:0]  direction;
    logic [7:0]  period;
    logic [15:0] step_count;
    logic        power_on;
  } cmd_t;

  function automatic logic [3:0] coil_of(input logic [1:0] ph);
    logic [3:0] pat;
    unique case (ph)
      2'd0: pat = 4'h3;
      2'd1: pat = 4'h6;
      2'd2: pat = 4'hc;
      2'd3: pat = 4'h9;
      default: pat = 4'h3;
    endcase
    return pat;
  endfunction

endpackage

FILE: src/msrc_front.sv
module msrc_front
  import msrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [1:0]  motor,
  input  logic [1:0]  direction,
  input  logic [7:0]  steps_per_second,
  input  logic [15:0] step_count,
  input  logic        power_on,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        full
);

  front_state_t state, state_next;
  cmd_t         cmd;
  logic [10:0]  dividend;
  logic [7:0]   divisor;
  logic [7:0]   rem;
  logic [7:0]   quot;
  logic [3:0]   bit_cnt;

  logic [8:0]   trial;
  logic         ge;
  logic [7:0]   rem_next;
  logic [7:0]   quot_next;
  logic [7:0]   pps_sat;
  logic         accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    if (steps_per_second < PPS_MIN) begin
      pps_sat = PPS_MIN;
    end else if (steps_per_second > PPS_MAX) begin
      pps_sat = PPS_MAX;
    end else begin
      pps_sat = steps_per_second;
    end
  end

  always_comb begin
    trial     = {rem, dividend[DIV_W-1]};
    ge        = trial >= {1'b0, divisor};
    rem_next  = ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
    quot_next = {quot[6:0], ge};
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    push       = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (mode == MODE_START) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        if (bit_cnt == '0) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.mode       <= mode;
      cmd.motor      <= motor;
      cmd.direction  <= direction;
      cmd.period     <= '0;
      cmd.step_count <= step_count;
      cmd.power_on   <= power_on;
      divisor        <= pps_sat;
      dividend       <= DIVIDEND;
      rem            <= '0;
      quot           <= '0;
      bit_cnt        <= DIV_LAST;
    end else if (state == F_DIV) begin
      dividend <= {dividend[DIV_W-2:0], 1'b0};
      rem      <= rem_next;
      quot     <= quot_next;
      bit_cnt  <= bit_cnt - 4'd1;
      // quotient never exceeds 200, so the low byte is the whole of it
      if (bit_cnt == '0) begin
        cmd.period <= quot_next;
      end
    end
  end

endmodule

FILE: src/msrc_queue.sv
module msrc_queue
  import msrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/msrc_back.sv
module msrc_back
  import msrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] motor_out,
  output logic [3:0] coil_pattern,
  output logic       drive_enabled,
  output logic       stepped,
  output logic       running
);

  logic [1:0]  phase          [MOTOR_COUNT];
  logic [15:0] remaining_steps[MOTOR_COUNT];
  logic [7:0]  step_period    [MOTOR_COUNT];
  logic [7:0]  tick_counter   [MOTOR_COUNT];
  logic [1:0]  step_direction [MOTOR_COUNT];
  logic        powered        [MOTOR_COUNT];

  logic                   valid_m;
  logic [MOTOR_IDX_W-1:0] idx;
  logic [1:0]             ph_n;
  logic [15:0]            rem_n;
  logic [7:0]             per_n;
  logic [7:0]             tc_n;
  logic [7:0]             tc_inc;
  logic [1:0]             dir_n;
  logic                   pow_n;
  logic                   step_n;
  logic                   all_off;

  assign pop = !empty && (!out_valid || !out_stall);

  always_comb begin
    valid_m = int'(cmd.motor) < MOTOR_COUNT;
    idx     = valid_m ? MOTOR_IDX_W'(cmd.motor) : '0;
    ph_n    = phase[idx];
    rem_n   = remaining_steps[idx];
    per_n   = step_period[idx];
    tc_n    = tick_counter[idx];
    dir_n   = step_direction[idx];
    pow_n   = powered[idx];
    tc_inc  = tick_counter[idx] + 8'd1;
    step_n  = 1'b0;
    all_off = 1'b0;
    unique case (mode_t'(cmd.mode))
      MODE_TICK: begin
        if (remaining_steps[idx] != '0) begin
          if (tc_inc == step_period[idx]) begin
            tc_n   = '0;
            step_n = valid_m;
            ph_n   = phase[idx] + step_direction[idx];
            if (remaining_steps[idx] != ENDLESS) begin
              rem_n = remaining_steps[idx] - 16'd1;
            end
          end else begin
            tc_n = tc_inc;
          end
        end
      end
      MODE_START: begin
        dir_n = cmd.direction;
        per_n = cmd.period;
        tc_n  = '0;
        rem_n = cmd.step_count;
        pow_n = 1'b1;
      end
      MODE_STOP: begin
        rem_n = '0;
      end
      MODE_POWER: begin
        pow_n = cmd.power_on;
      end
      MODE_ALL_OFF: begin
        all_off = 1'b1;
        rem_n   = '0;
        pow_n   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        phase[k]           <= '0;
        remaining_steps[k] <= '0;
        step_period[k]     <= '0;
        tick_counter[k]    <= '0;
        step_direction[k]  <= '0;
        powered[k]         <= 1'b0;
      end
    end else if (pop) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        if (all_off) begin
          remaining_steps[k] <= '0;
          powered[k]         <= 1'b0;
        end else if (valid_m && idx == MOTOR_IDX_W'(k)) begin
          phase[k]           <= ph_n;
          remaining_steps[k] <= rem_n;
          step_period[k]     <= per_n;
          tick_counter[k]    <= tc_n;
          step_direction[k]  <= dir_n;
          powered[k]         <= pow_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // a motor outside the array reports its motor number with zero coil pattern and status flags
  always_ff @(posedge clk) begin
    if (pop) begin
      motor_out     <= cmd.motor;
      coil_pattern  <= valid_m ? coil_of(ph_n) : 4'h0;
      drive_enabled <= valid_m && pow_n;
      stepped       <= step_n;
      running       <= valid_m && (rem_n != '0);
    end
  end

endmodule

FILE: src/multi_stepper_rate_controller.sv
// Three-motor full-step controller driven by one word stream of ticks and commands.
// Each accepted word yields exactly one result word for the addressed motor, after
// its update. The front end takes a new word only after pushing the last; a start
// word first gets its 2000/pps step period from a restoring divider, one quotient
// bit a cycle. A two-word queue sits between the front end and the motor state
// unit, which updates the motor state and loads the output register on the same
// pop, so result stalls do not hold up intake until the queue fills.
module multi_stepper_rate_controller
  import msrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [1:0]  motor,
  input  logic [1:0]  direction,
  input  logic [7:0]  steps_per_second,
  input  logic [15:0] step_count,
  input  logic        power_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  motor_out,
  output logic [3:0]  coil_pattern,
  output logic        drive_enabled,
  output logic        stepped,
  output logic        running
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  msrc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .motor            (motor),
    .direction        (direction),
    .steps_per_second (steps_per_second),
    .step_count       (step_count),
    .power_on         (power_on),
    .push             (push),
    .push_cmd         (push_cmd),
    .full             (full)
  );

  msrc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  msrc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (pop_cmd),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .motor_out     (motor_out),
    .coil_pattern  (coil_pattern),
    .drive_enabled (drive_enabled),
    .stepped       (stepped),
    .running       (running)
  );

endmodule

FILE: src/msrc_checker.sv
module msrc_checker
  import msrc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] motor_out,
  input logic [3:0] coil_pattern,
  input logic       drive_enabled,
  input logic       stepped,
  input logic       running
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  a_bad_motor: assert property (@(posedge clk) disable iff (rst)
    out_valid && int'(motor_out) >= MOTOR_COUNT |->
      coil_pattern == 4'h0 && !drive_enabled && !stepped && !running)
    else $error("absent motor reported non-zero status");

  a_coil_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && int'(motor_out) < MOTOR_COUNT |->
      coil_pattern == 4'h3 || coil_pattern == 4'h6 ||
      coil_pattern == 4'hc || coil_pattern == 4'h9)
    else $error("coil pattern not a full-step phase");

endmodule

bind multi_stepper_rate_controller msrc_checker u_msrc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .motor_out     (motor_out),
  .coil_pattern  (coil_pattern),
  .drive_enabled (drive_enabled),
  .stepped       (stepped),
  .running       (running)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import msrc_pkg::*;

  localparam int          LIMIT_CYCLES  = 1_000_000;
  localparam int          RANDOM_WORDS  = 2000;
  localparam int          PHASE_COUNT   = 8;
  localparam int          SETTLE_CYCLES = 40;
  localparam logic [2:0]  MODE_SPARE    = 3'd7;
  localparam logic [3:0]  COIL_BY_PHASE [4] = '{4'h3, 4'h6, 4'hc, 4'h9};

  typedef struct {
    logic [2:0]  mode;
    logic [1:0]  motor;
    logic [1:0]  dir;
    logic [7:0]  pps;
    logic [15:0] count;
    logic        on;
  } stim_t;

  typedef struct {
    logic [1:0] motor;
    logic [3:0] coil;
    logic       enabled;
    logic       stepped;
    logic       running;
  } coil_word_t;

  typedef struct {
    stim_t      w;
    int         reps;
    bit         typed;
    coil_word_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  mode;
  logic [1:0]  motor;
  logic [1:0]  direction;
  logic [7:0]  steps_per_second;
  logic [15:0] step_count;
  logic        power_on;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  motor_out;
  logic [3:0]  coil_pattern;
  logic        drive_enabled;
  logic        stepped;
  logic        running;

  // predicted per-motor state
  logic [1:0]  phase_of   [MOTOR_COUNT];
  logic [15:0] steps_left [MOTOR_COUNT];
  logic [7:0]  period     [MOTOR_COUNT];
  logic [7:0]  divider    [MOTOR_COUNT];
  logic [1:0]  heading    [MOTOR_COUNT];
  logic        drive_on   [MOTOR_COUNT];

  coil_word_t  coil_words_due[$];
  int          failures;
  int          words_sent;
  int          words_checked;
  int          steps_seen;
  int          starts_sent;
  int          cycles = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  plan_row_t   plan [16];

  multi_stepper_rate_controller DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .motor            (motor),
    .direction        (direction),
    .steps_per_second (steps_per_second),
    .step_count       (step_count),
    .power_on         (power_on),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .motor_out        (motor_out),
    .coil_pattern     (coil_pattern),
    .drive_enabled    (drive_enabled),
    .stepped          (stepped),
    .running          (running)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d words still due", $time, coil_words_due.size());
      $display("multi_stepper_rate_controller verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic coil_word_t apply_word(input stim_t w);
    coil_word_t r;
    logic [7:0] rate;
    logic       hit;
    int         k;
    hit = 1'b0;
    if (w.mode == MODE_ALL_OFF) begin
      for (k = 0; k < MOTOR_COUNT; k++) begin
        steps_left[k] = '0;
        drive_on[k]   = 1'b0;
      end
    end else if (w.motor < MOTOR_COUNT) begin
      case (w.mode)
        MODE_TICK: begin
          if (steps_left[w.motor] != '0) begin
            divider[w.motor] = divider[w.motor] + 8'd1;
            if (divider[w.motor] == period[w.motor]) begin
              divider[w.motor] = '0;
              if (steps_left[w.motor] != ENDLESS)
                steps_left[w.motor] = steps_left[w.motor] - 16'd1;
              phase_of[w.motor] = phase_of[w.motor] + heading[w.motor];
              hit = 1'b1;
            end
          end
        end
        MODE_START: begin
          rate = (w.pps < PPS_MIN) ? PPS_MIN : (w.pps > PPS_MAX) ? PPS_MAX : w.pps;
          heading[w.motor]    = w.dir;
          period[w.motor]     = 8'(int'(DIVIDEND) / int'(rate));
          divider[w.motor]    = '0;
          steps_left[w.motor] = w.count;
          drive_on[w.motor]   = 1'b1;
        end
        MODE_STOP:  steps_left[w.motor] = '0;
        MODE_POWER: drive_on[w.motor] = w.on;
        default: ;
      endcase
    end
    r.motor = w.motor;
    if (w.motor < MOTOR_COUNT) begin
      r.coil    = COIL_BY_PHASE[phase_of[w.motor]];
      r.enabled = drive_on[w.motor];
      r.stepped = hit;
      r.running = (steps_left[w.motor] != '0);
    end else begin
      r.coil    = '0;
      r.enabled = 1'b0;
      r.stepped = 1'b0;
      r.running = 1'b0;
    end
    return r;
  endfunction

  // mostly ticks on fast motors with short runs, so that counts actually run out
  function automatic stim_t random_word();
    stim_t w;
    int    pick;
    pick    = $urandom_range(0, 99);
    w.motor = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, MOTOR_COUNT - 1));
    w.dir   = 2'($urandom);
    w.pps   = 8'($urandom);
    w.count = 16'($urandom);
    w.on    = 1'($urandom);
    if (pick < 72) begin
      w.mode = MODE_TICK;
    end else if (pick < 82) begin
      w.mode = MODE_START;
      if ($urandom_range(0, 3) != 0) w.pps = 8'($urandom_range(100, 255));
      case ($urandom_range(0, 5))
        0: w.count = ENDLESS;
        1: ;
        default: w.count = 16'($urandom_range(1, 6));
      endcase
    end else if (pick < 87) begin
      w.mode = MODE_STOP;
    end else if (pick < 93) begin
      w.mode = MODE_POWER;
    end else if (pick < 96) begin
      w.mode = MODE_ALL_OFF;
    end else begin
      w.mode = 3'($urandom_range(5, 7));
    end
    return w;
  endfunction

  // returns at the edge that took the word; in_valid stays as driven
  task automatic send_word(input stim_t w, input bit typed, input coil_word_t given);
    coil_word_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    mode             <= w.mode;
    motor            <= w.motor;
    direction        <= w.dir;
    steps_per_second <= w.pps;
    step_count       <= w.count;
    power_on         <= w.on;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = apply_word(w);
    coil_words_due.push_back(typed ? given : predicted);
    words_sent++;
    if (w.mode == MODE_START) starts_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (coil_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    coil_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (coil_words_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got motor %0d coil %0h",
                 $time, motor_out, coil_pattern);
        failures++;
      end else begin
        want = coil_words_due.pop_front();
        check_field("motor_out", want.motor, motor_out);
        check_field("coil_pattern", want.coil, coil_pattern);
        check_field("drive_enabled", want.enabled, drive_enabled);
        check_field("stepped", want.stepped, stepped);
        check_field("running", want.running, running);
        words_checked++;
        if (stepped) steps_seen++;
      end
    end
  end

  initial begin
    int         p;
    int         n;
    int         i;
    coil_word_t none;
    failures         = 0;
    words_sent       = 0;
    words_checked    = 0;
    steps_seen       = 0;
    starts_sent      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    none             = '{2'd0, 4'h0, 1'b0, 1'b0, 1'b0};
    for (i = 0; i < MOTOR_COUNT; i++) begin
      phase_of[i]   = '0;
      steps_left[i] = '0;
      period[i]     = '0;
      divider[i]    = '0;
      heading[i]    = '0;
      drive_on[i]   = 1'b0;
    end

    // fields: mode motor dir pps count on | repeats typed | motor coil en stepped running
    plan = '{
      '{'{MODE_TICK,    2'd0, 2'b00, 8'd0,   16'd0,     1'b0}, 1,  1'b1,
        '{2'd0, 4'h3, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_TICK,    2'd3, 2'b00, 8'd0,   16'd0,     1'b0}, 1,  1'b1,
        '{2'd3, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_START,   2'd3, 2'b01, 8'd100, 16'd5,     1'b0}, 1,  1'b1,
        '{2'd3, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_START,   2'd0, 2'b01, 8'd255, 16'd1,     1'b0}, 1,  1'b1,
        '{2'd0, 4'h3, 1'b1, 1'b0, 1'b1}},
      '{'{MODE_TICK,    2'd0, 2'b00, 8'd0,   16'd0,     1'b0}, 10, 1'b0, none},
      '{'{MODE_START,   2'd2, 2'b10, 8'd0,   16'hffff,  1'b0}, 1,  1'b1,
        '{2'd2, 4'h3, 1'b1, 1'b0, 1'b1}},
      '{'{MODE_TICK,    2'd2, 2'b00, 8'd0,   16'd0,     1'b0}, 2,  1'b0, none},
      '{'{MODE_STOP,    2'd2, 2'b00, 8'd0,   16'd0,     1'b0}, 1,  1'b1,
        '{2'd2, 4'h3, 1'b1, 1'b0, 1'b0}},
      '{'{MODE_POWER,   2'd2, 2'b00, 8'd0,   16'd0,     1'b0}, 1,  1'b1,
        '{2'd2, 4'h3, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_POWER,   2'd1, 2'b00, 8'd0,   16'd0,     1'b1}, 1,  1'b1,
        '{2'd1, 4'h3, 1'b1, 1'b0, 1'b0}},
      '{'{MODE_START,   2'd1, 2'b11, 8'd200, 16'hffff,  1'b0}, 1,  1'b1,
        '{2'd1, 4'h3, 1'b1, 1'b0, 1'b1}},
      '{'{MODE_ALL_OFF, 2'd1, 2'b00, 8'd0,   16'd0,     1'b0}, 1,  1'b1,
        '{2'd1, 4'h3, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_ALL_OFF, 2'd3, 2'b00, 8'd0,   16'd0,     1'b0}, 1,  1'b1,
        '{2'd3, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_POWER,   2'd3, 2'b00, 8'd0,   16'd0,     1'b1}, 1,  1'b1,
        '{2'd3, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_SPARE,   2'd0, 2'b00, 8'd0,   16'd0,     1'b0}, 1,  1'b0, none},
      '{'{MODE_START,   2'd0, 2'b00, 8'd9,   16'd0,     1'b0}, 1,  1'b1,
        '{2'd0, 4'h6, 1'b1, 1'b0, 1'b0}}
    };

    in_valid         <= 1'b0;
    mode             <= MODE_TICK;
    motor            <= '0;
    direction        <= '0;
    steps_per_second <= '0;
    step_count       <= '0;
    power_on         <= 1'b0;
    rst              <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r])
      for (n = 0; n < plan[r].reps; n++)
        send_word(plan[r].w, plan[r].typed, plan[r].want);
    // hold off until the pipe is empty before the random part
    drain();

    for (p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (n = 0; n < RANDOM_WORDS / PHASE_COUNT; n++)
        send_word(random_word(), 1'b0, none);
      drain();
    end

    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d starts), checked %0d results, %0d of them steps.",
             words_sent, starts_sent, words_checked, steps_seen);
    $display("Idle and stall mixes covered: none, sender, receiver, both; %0d mismatches.",
             failures);
    if (failures == 0 && coil_words_due.size() == 0)
      $display("multi_stepper_rate_controller verification clean");
    else
      $display("multi_stepper_rate_controller verification failed");
    $finish;
  end

endmodule
